>>> rtl/abcdq_pkg.sv
// Shared constants, types, and the quarter-wave sine table for the abc-to-dq Park transform.
package abcdq_pkg;

	localparam int SAMPLE_BITS     = 16;
	localparam int ANGLE_BITS      = 16;
	localparam int TABLE_ADDR_BITS = 10;

	localparam int LANES         = 3;
	localparam int OUT_BITS      = SAMPLE_BITS + 2;
	localparam int PHASE_BITS    = TABLE_ADDR_BITS + 2;
	localparam int ROM_ADDR_BITS = TABLE_ADDR_BITS + 1;
	localparam int TABLE_SIZE    = 1 << TABLE_ADDR_BITS;
	localparam int ROM_DEPTH     = TABLE_SIZE + 1;
	localparam int MAG_BITS      = 15;
	localparam int SINE_BITS     = MAG_BITS + 1;
	localparam int PROD_BITS     = SAMPLE_BITS + SINE_BITS;
	localparam int SUM_BITS      = PROD_BITS + 2;
	localparam int GAIN_BITS     = 16;
	localparam int SCALE_BITS    = SUM_BITS + GAIN_BITS;
	localparam int GAIN_SHIFT    = 30;

	// The 2/3 gain in Q15 and the half LSB used to round the Q45 product to Q15.
	localparam logic signed [GAIN_BITS-1:0]  GAIN_Q15   = GAIN_BITS'(21845);
	localparam logic signed [SCALE_BITS-1:0] ROUND_HALF = SCALE_BITS'(1) <<< (GAIN_SHIFT - 1);

	// One third and one quarter of a turn in angle units.
	localparam logic [ANGLE_BITS-1:0] THIRD =
		ANGLE_BITS'(((longint'(1) << ANGLE_BITS) + 1) / 3);
	localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

	// Pipeline stage enables, driven by the top level.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} pipe_en_t;

	// Table address and sign derived from one angle.
	typedef struct packed {
		logic                     neg;
		logic [ROM_ADDR_BITS-1:0] idx;
	} rom_addr_t;

	typedef logic [MAG_BITS-1:0] sine_rom_t [ROM_DEPTH];

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam int TAYLOR_TERMS = 8;
	localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] =
		'{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272};

	// Builds the quarter-wave table from a truncated odd Taylor series in Q30.
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t       rom;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          acc;
		longint          v;
		for (int k = 0; k < ROM_DEPTH; k++) begin
			x    = (HALF_PI_Q30 * longint'(k)) >> TABLE_ADDR_BITS;
			x2   = (x * x) >> 30;
			term = x;
			acc  = longint'(x);
			for (int n = 0; n < TAYLOR_TERMS; n++) begin
				term = (term * x2) >> 30;
				term = term / TAYLOR_DIV[n];
				if (n[0] == 1'b0) begin
					acc = acc - longint'(term);
				end else begin
					acc = acc + longint'(term);
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			v = (acc + 16384) >>> 15;
			if (v > 32767) begin
				v = 32767;
			end
			rom[k] = MAG_BITS'(v);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	// Maps an angle onto the quarter-wave table: mirrored index and sign.
	function automatic rom_addr_t rom_addr(input logic [ANGLE_BITS-1:0] angle);
		logic [ANGLE_BITS+PHASE_BITS-1:0] padded;
		logic [PHASE_BITS-1:0]            phase;
		logic [ROM_ADDR_BITS-1:0]         idx;
		rom_addr_t                        r;
		padded = {angle, PHASE_BITS'(0)};
		phase  = padded[ANGLE_BITS +: PHASE_BITS];
		idx    = {1'b0, phase[TABLE_ADDR_BITS-1:0]};
		r.neg  = phase[PHASE_BITS-1];
		r.idx  = phase[PHASE_BITS-2] ? (ROM_ADDR_BITS'(TABLE_SIZE) - idx) : idx;
		return r;
	endfunction

endpackage

>>> rtl/abcdq_in_if.sv
// Input channel: three phase currents and an electrical angle with valid/ready.
interface abcdq_in_if import abcdq_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] phase_a_current;
	logic signed [SAMPLE_BITS-1:0] phase_b_current;
	logic signed [SAMPLE_BITS-1:0] phase_c_current;
	logic        [ANGLE_BITS-1:0]  electrical_angle;

	modport source (
		output valid, phase_a_current, phase_b_current, phase_c_current, electrical_angle,
		input  ready
	);
	modport sink (
		input  valid, phase_a_current, phase_b_current, phase_c_current, electrical_angle,
		output ready
	);
endinterface

>>> rtl/abcdq_out_if.sv
// Output channel: d and q components with valid/ready.
interface abcdq_out_if import abcdq_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [OUT_BITS-1:0] d_component;
	logic signed [OUT_BITS-1:0] q_component;

	modport source (
		output valid, d_component, q_component,
		input  ready
	);
	modport sink (
		input  valid, d_component, q_component,
		output ready
	);
endinterface

>>> rtl/abcdq_lane.sv
// One phase lane: sine and cosine table lookup, then current times sine and cosine.
module abcdq_lane import abcdq_pkg::*; (
	input  logic                        clk,
	input  pipe_en_t                    pipe_en,
	input  logic signed [SAMPLE_BITS-1:0] current,
	input  logic        [ANGLE_BITS-1:0]  angle,
	output logic signed [PROD_BITS-1:0]   sin_prod,
	output logic signed [PROD_BITS-1:0]   cos_prod
);

	rom_addr_t                     sin_addr;
	rom_addr_t                     cos_addr;
	logic        [MAG_BITS-1:0]    sin_mag_s1;
	logic        [MAG_BITS-1:0]    cos_mag_s1;
	logic                          sin_neg_s1;
	logic                          cos_neg_s1;
	logic signed [SAMPLE_BITS-1:0] current_s1;
	logic signed [SINE_BITS-1:0]   sin_val;
	logic signed [SINE_BITS-1:0]   cos_val;
	logic signed [PROD_BITS-1:0]   sin_prod_s2;
	logic signed [PROD_BITS-1:0]   cos_prod_s2;

	// The cosine is the sine a quarter turn ahead.
	always_comb begin
		sin_addr = rom_addr(angle);
		cos_addr = rom_addr(angle + QUARTER);
	end

	always_ff @(posedge clk) begin
		if (pipe_en.s1) begin
			sin_mag_s1 <= SINE_ROM[sin_addr.idx];
			cos_mag_s1 <= SINE_ROM[cos_addr.idx];
			sin_neg_s1 <= sin_addr.neg;
			cos_neg_s1 <= cos_addr.neg;
			current_s1 <= current;
		end
	end

	always_comb begin
		sin_val = sin_neg_s1 ? -$signed({1'b0, sin_mag_s1}) : $signed({1'b0, sin_mag_s1});
		cos_val = cos_neg_s1 ? -$signed({1'b0, cos_mag_s1}) : $signed({1'b0, cos_mag_s1});
	end

	always_ff @(posedge clk) begin
		if (pipe_en.s2) begin
			sin_prod_s2 <= PROD_BITS'(current_s1) * PROD_BITS'(sin_val);
			cos_prod_s2 <= PROD_BITS'(current_s1) * PROD_BITS'(cos_val);
		end
	end

	assign sin_prod = sin_prod_s2;
	assign cos_prod = cos_prod_s2;

endmodule

>>> rtl/abcdq_merge.sv
// Merge stage: sums the lane products and applies the rounded 2/3 gain.
module abcdq_merge import abcdq_pkg::*; (
	input  logic                        clk,
	input  pipe_en_t                    pipe_en,
	input  logic signed [PROD_BITS-1:0] sin_prod [LANES],
	input  logic signed [PROD_BITS-1:0] cos_prod [LANES],
	output logic signed [OUT_BITS-1:0]  d_component,
	output logic signed [OUT_BITS-1:0]  q_component
);

	logic signed [SUM_BITS-1:0]   d_sum_s3;
	logic signed [SUM_BITS-1:0]   q_sum_s3;
	logic signed [SCALE_BITS-1:0] d_scaled;
	logic signed [SCALE_BITS-1:0] q_scaled;
	logic signed [OUT_BITS-1:0]   d_out_s4;
	logic signed [OUT_BITS-1:0]   q_out_s4;

	always_ff @(posedge clk) begin
		if (pipe_en.s3) begin
			d_sum_s3 <= SUM_BITS'(sin_prod[0]) + SUM_BITS'(sin_prod[1]) + SUM_BITS'(sin_prod[2]);
			q_sum_s3 <= SUM_BITS'(cos_prod[0]) + SUM_BITS'(cos_prod[1]) + SUM_BITS'(cos_prod[2]);
		end
	end

	// Round half up, then an arithmetic shift from Q45 to Q15; the result never overflows.
	always_comb begin
		d_scaled = SCALE_BITS'(d_sum_s3) * SCALE_BITS'(GAIN_Q15) + ROUND_HALF;
		q_scaled = SCALE_BITS'(q_sum_s3) * SCALE_BITS'(GAIN_Q15) + ROUND_HALF;
	end

	always_ff @(posedge clk) begin
		if (pipe_en.s4) begin
			d_out_s4 <= d_scaled[GAIN_SHIFT +: OUT_BITS];
			q_out_s4 <= q_scaled[GAIN_SHIFT +: OUT_BITS];
		end
	end

	assign d_component = d_out_s4;
	assign q_component = q_out_s4;

endmodule

>>> rtl/abc_to_dq_park_transform_top.sv
// Top level of the three-phase abc-to-dq Park transform.
// The samples channel takes one transaction holding phase A, B and C currents
// (signed Q1.15) and an electrical angle (unsigned fraction of a turn). The
// result channel returns one transaction per input with the d and q components,
// each 2/3 of the sine- or cosine-weighted current sum, rounded half up.
// The datapath is a four-stage pipeline. Three lanes, one per phase, look up
// the sine and cosine of their angle in a quarter-wave table (stage 1) and
// multiply by the phase current (stage 2). The merge stage sums the lanes
// (stage 3) and applies the 2/3 gain with rounding (stage 4).
// A sample accepted at a rising edge passes through stages 1, 2, 3 and 4 in
// order and is shown as a valid result once it holds stage 4; a stall of the
// receiver can hold it on the way. The block takes one transaction every
// cycle while the receiver keeps result.ready high.
// Each stage has its own valid bit and advances when the next stage is empty
// or moving, so bubbles collapse. When the receiver stalls, the result holds
// and the earlier stages keep filling; samples.ready falls only once all four
// stages are full. Reset clears the valid bits; nothing else needs clearing.
module abc_to_dq_park_transform_top import abcdq_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	abcdq_in_if.sink   samples,
	abcdq_out_if.source result
);

	pipe_en_t                    pipe_en;
	logic                        valid_s1;
	logic                        valid_s2;
	logic                        valid_s3;
	logic                        valid_s4;
	logic signed [SAMPLE_BITS-1:0] lane_current [LANES];
	logic        [ANGLE_BITS-1:0]  lane_angle   [LANES];
	logic signed [PROD_BITS-1:0]   sin_prod     [LANES];
	logic signed [PROD_BITS-1:0]   cos_prod     [LANES];
	logic signed [OUT_BITS-1:0]    d_value;
	logic signed [OUT_BITS-1:0]    q_value;

	// A stage may load when it is empty or when its content moves on.
	always_comb begin
		pipe_en.s4 = !valid_s4 || result.ready;
		pipe_en.s3 = !valid_s3 || pipe_en.s4;
		pipe_en.s2 = !valid_s2 || pipe_en.s3;
		pipe_en.s1 = !valid_s1 || pipe_en.s2;
	end

	assign samples.ready = pipe_en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (pipe_en.s1) valid_s1 <= samples.valid;
			if (pipe_en.s2) valid_s2 <= valid_s1;
			if (pipe_en.s3) valid_s3 <= valid_s2;
			if (pipe_en.s4) valid_s4 <= valid_s3;
		end
	end

	// Phase B sits a third of a turn behind phase A, phase C a third ahead.
	always_comb begin
		lane_current[0] = samples.phase_a_current;
		lane_current[1] = samples.phase_b_current;
		lane_current[2] = samples.phase_c_current;
		lane_angle[0]   = samples.electrical_angle;
		lane_angle[1]   = samples.electrical_angle - THIRD;
		lane_angle[2]   = samples.electrical_angle + THIRD;
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		abcdq_lane u_lane (
			.clk      (clk),
			.pipe_en  (pipe_en),
			.current  (lane_current[g]),
			.angle    (lane_angle[g]),
			.sin_prod (sin_prod[g]),
			.cos_prod (cos_prod[g])
		);
	end

	abcdq_merge u_merge (
		.clk         (clk),
		.pipe_en     (pipe_en),
		.sin_prod    (sin_prod),
		.cos_prod    (cos_prod),
		.d_component (d_value),
		.q_component (q_value)
	);

	assign result.valid       = valid_s4;
	assign result.d_component = d_value;
	assign result.q_component = q_value;

	// An accepted sample always lands in the first stage.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.ready |=> valid_s1)
		else $error("accepted sample did not enter stage 1");

	// Input backpressure only happens with every stage occupied.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!samples.ready |-> valid_s1 && valid_s2 && valid_s3 && valid_s4)
		else $error("input stalled while the pipeline had a free stage");

	// A valid item in stage 3 moves into the output stage whenever it is enabled.
	a_s3_to_s4: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && pipe_en.s4 |=> valid_s4)
		else $error("item lost between stage 3 and the output stage");

endmodule
